// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the palette expander.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked property, disabled while the active-low reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property checked during reset as well.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

// ----- src/ippe_pkg.sv -----
// Shared types and constants of the indexed pixel palette expander.
package ippe_pkg;

    localparam int PALETTE_SIZE = 16;
    localparam int NUM_LANES    = 4;
    localparam int COLOR_W      = 8;
    localparam int INDEX_W      = 4;
    localparam int WORD_W       = 32;

    // depth_mode codes; the high bit set means direct pass-through
    localparam logic [1:0] MODE_TWO_BIT  = 2'd0;
    localparam logic [1:0] MODE_FOUR_BIT = 2'd1;
    localparam logic [1:0] MODE_DIRECT   = 2'd2;

    // register indexes
    localparam logic [2:0] REG_DEPTH_MODE = 3'd0;
    localparam logic [2:0] REG_PAL_0_3    = 3'd1;
    localparam logic [2:0] REG_PAL_4_7    = 3'd2;
    localparam logic [2:0] REG_PAL_8_11   = 3'd3;
    localparam logic [2:0] REG_PAL_12_15  = 3'd4;

    localparam logic [1:0]  DEPTH_MODE_RST = MODE_FOUR_BIT;
    localparam logic [31:0] PAL_0_3_RST    = 32'h100C0804;
    localparam logic [31:0] PAL_4_7_RST    = 32'h01001C14;
    localparam logic [31:0] PAL_8_11_RST   = 32'h40200302;
    localparam logic [31:0] PAL_12_15_RST  = 32'hE0A08060;

    typedef logic [PALETTE_SIZE-1:0][COLOR_W-1:0] palette_t;

    typedef struct packed {
        logic [1:0] depth_mode;
        palette_t   palette;
    } cfg_t;

endpackage

// ----- src/indexed_pixel_palette_expand.sv -----
// Top level of the indexed pixel palette expander.
//
//  channel  | dir | word contents
//  ---------+-----+--------------------------------------------------
//  s_axis   | in  | tdata[31:0] memory_word
//  m_axis   | out | tdata[31:0] pixel_group, tlast last_of_word
//  apb      | in  | regs 0..4 at byte addr 0,4,8,12,16
//
// A word is held while four lookup lanes build one result word per cycle unless the
// output stalls: four results per input word in two-bit mode, two in four-bit mode,
// one in direct mode. Input passes through the hold register and the output register;
// the next word is taken in the cycle the current one emits its last result.
// Reset is synchronous; output backpressure stalls the hold stage, and with it s_tready.
module indexed_pixel_palette_expand (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] memory_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] pixel_group
    output logic        m_tlast,   // last_of_word
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "assert_macros.svh"

    ippe_pkg::cfg_t cfg;

    ippe_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [31:0] hold_word_reg;
    logic [1:0]  cnt_reg;
    logic        hold_valid_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_last_reg;

    logic        direct;
    logic        two_bit;
    logic        advance;
    logic        s_accept;
    logic [31:0] merged;

    assign direct   = cfg.depth_mode[1];
    assign two_bit  = (cfg.depth_mode == ippe_pkg::MODE_TWO_BIT);
    assign advance  = hold_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !hold_valid_reg || (advance && (cnt_reg == 2'd0));
    assign s_accept = s_tvalid && s_tready;

    genvar p;
    generate
        for (p = 0; p < ippe_pkg::NUM_LANES; p++) begin : g_lane
            logic [ippe_pkg::INDEX_W-1:0] field;
            assign field = two_bit ? {2'b00, hold_word_reg[2*p +: 2]}
                                   : hold_word_reg[ippe_pkg::INDEX_W*p +: ippe_pkg::INDEX_W];
            ippe_lane u_lane (
                .two_bit (two_bit),
                .field   (field),
                .palette (cfg.palette),
                .color   (merged[ippe_pkg::COLOR_W*p +: ippe_pkg::COLOR_W])
            );
        end
    endgenerate

    // hold stage: the word shifts down by one group's worth of indices per result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= 2'd0;
        end else if (s_accept) begin
            hold_valid_reg <= 1'b1;
            hold_word_reg  <= s_tdata;
            if (direct) begin
                cnt_reg <= 2'd0;
            end else if (two_bit) begin
                cnt_reg <= 2'd3;
            end else begin
                cnt_reg <= 2'd1;
            end
        end else if (advance) begin
            if (cnt_reg == 2'd0) begin
                hold_valid_reg <= 1'b0;
            end else begin
                cnt_reg       <= cnt_reg - 2'd1;
                hold_word_reg <= two_bit ? {8'd0, hold_word_reg[31:8]}
                                         : {16'd0, hold_word_reg[31:16]};
            end
        end
    end

    // merge stage: lane colors or the raw word into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= direct ? hold_word_reg : merged;
            out_last_reg  <= (cnt_reg == 2'd0);
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `ASSERT_CLK_RST(a_accept_loads, aclk, aresetn, s_accept |=> hold_valid_reg,
        "accepted word not held")
    `ASSERT_CLK_RST(a_more_groups, aclk, aresetn,
        (advance && !s_accept && (cnt_reg != 2'd0)) |=> hold_valid_reg,
        "word dropped before its last group")
    `ASSERT_CLK_RST(a_direct_single, aclk, aresetn,
        (hold_valid_reg && direct) |-> (cnt_reg == 2'd0),
        "direct mode word with several groups")
    `ASSERT_CLK_RST(a_four_bit_two, aclk, aresetn,
        (hold_valid_reg && (cfg.depth_mode == ippe_pkg::MODE_FOUR_BIT)) |-> (cnt_reg <= 2'd1),
        "four-bit word with too many groups")
    `ASSERT_CLK(a_reset_idle, aclk, !aresetn |=> (!m_tvalid && s_tready),
        "not idle after reset")

endmodule

// ----- src/ippe_regs.sv -----
// APB register file: depth mode and the sixteen-entry palette.
module ippe_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output ippe_pkg::cfg_t     cfg
);

    logic [1:0]  mode_reg;
    logic [31:0] pal0_reg, pal1_reg, pal2_reg, pal3_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ippe_pkg::DEPTH_MODE_RST;
            pal0_reg <= ippe_pkg::PAL_0_3_RST;
            pal1_reg <= ippe_pkg::PAL_4_7_RST;
            pal2_reg <= ippe_pkg::PAL_8_11_RST;
            pal3_reg <= ippe_pkg::PAL_12_15_RST;
        end else if (wr_en) begin
            case (reg_idx)
                ippe_pkg::REG_DEPTH_MODE: mode_reg <= pwdata[1:0];
                ippe_pkg::REG_PAL_0_3:    pal0_reg <= pwdata;
                ippe_pkg::REG_PAL_4_7:    pal1_reg <= pwdata;
                ippe_pkg::REG_PAL_8_11:   pal2_reg <= pwdata;
                ippe_pkg::REG_PAL_12_15:  pal3_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ippe_pkg::REG_DEPTH_MODE: prdata = {30'd0, mode_reg};
            ippe_pkg::REG_PAL_0_3:    prdata = pal0_reg;
            ippe_pkg::REG_PAL_4_7:    prdata = pal1_reg;
            ippe_pkg::REG_PAL_8_11:   prdata = pal2_reg;
            ippe_pkg::REG_PAL_12_15:  prdata = pal3_reg;
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg.depth_mode = mode_reg;
    assign cfg.palette    = ippe_pkg::palette_t'({pal3_reg, pal2_reg, pal1_reg, pal0_reg});

endmodule

// ----- src/ippe_lane.sv -----
// One pixel lane: looks the lane's index field up in the palette.
module ippe_lane (
    input  logic                            two_bit,
    input  logic [ippe_pkg::INDEX_W-1:0]    field,
    input  ippe_pkg::palette_t              palette,
    output logic [ippe_pkg::COLOR_W-1:0]    color
);

    logic [ippe_pkg::INDEX_W-1:0] idx;

    // two-bit indices only reach entries 0 to 3
    assign idx   = two_bit ? {2'b00, field[1:0]} : field;
    assign color = palette[idx];

endmodule
